>>> design/mlp221_pkg.sv
// shared constants, saturation and sigmoid table generation for the 2-2-1 training block
package mlp221_pkg;

    localparam int unsigned ONE_Q12   = 4096;
    localparam longint      Q30       = 64'sd1073741824;
    localparam longint      EXP_M1_Q30 = 64'sd395007543;

    localparam logic signed [15:0] RST_W1     = 16'sd1638;
    localparam logic signed [15:0] RST_W2     = 16'sd410;
    localparam logic signed [15:0] RST_WB     = -16'sd819;
    localparam logic signed [15:0] RST_VA1    = 16'sd2458;
    localparam logic signed [15:0] RST_VB1    = -16'sd410;
    localparam logic signed [15:0] RST_VBIAS1 = 16'sd1229;
    localparam logic signed [15:0] RST_VA2    = -16'sd1229;
    localparam logic signed [15:0] RST_VB2    = 16'sd1638;
    localparam logic signed [15:0] RST_VBIAS2 = 16'sd2048;
    localparam logic [12:0]         RST_ALPHA  = 13'd1024;
    localparam logic [12:0]         Q12_ONE    = 13'd4096;

    typedef logic signed [15:0] weight_t;

    // clamp a widened sum to the 16-bit weight range
    function automatic weight_t sat16(input logic signed [24:0] x);
        weight_t r;
        if (x > 25'sd32767) begin
            r = 16'sh7fff;
        end else if (x < -25'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = x[15:0];
        end
        return r;
    endfunction

    // unsigned quotient by shift and subtract, only for table constants
    function automatic longint unsigned udiv(input longint unsigned num,
                                             input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem    = rem - den;
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sigmoid of a non-negative q4.12 code, exp by taylor series and powers of exp(-1)
    function automatic longint sig_pos(input longint u);
        longint unsigned f;
        longint unsigned term;
        longint          sum;
        longint          e;
        longint          k;
        f    = (longint'(u) & 64'd4095) << 18;
        term = longint'(Q30);
        sum  = Q30;
        for (int n = 1; n <= 14; n++) begin
            term = udiv((term * f) >> 30, n);
            if ((n & 1) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        e = (sum < 0) ? 64'sd0 : sum;
        for (k = 0; k < (u >>> 12); k++) begin
            e = (e * EXP_M1_Q30) >>> 30;
        end
        return longint'(udiv(longint'(ONE_Q12) * Q30 + ((Q30 + e) >>> 1), Q30 + e));
    endfunction

    // table entry k for a table of the given depth, value at the bin center
    function automatic longint sig_entry(input longint k, input longint depth);
        longint c;
        c = longint'(udiv((2 * k + 1) * 32768, depth)) - 32768;
        return (c >= 0) ? sig_pos(c) : longint'(ONE_Q12) - sig_pos(-c);
    endfunction

endpackage

>>> design/mlp221_sig_lut.sv
// sigmoid lookup: bin index from a saturated net input and a constant table
module mlp221_sig_lut #(
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic signed [15:0] net_in,
    output logic [12:0]        sig_out
);

    localparam int IW = (SIGMOID_TABLE_DEPTH > 1) ? $clog2(SIGMOID_TABLE_DEPTH) : 1;
    localparam int PW = 16 + IW + 1;

    logic [12:0]   rom [SIGMOID_TABLE_DEPTH];
    logic [15:0]   offs;
    logic [PW-1:0] prod;
    logic [IW-1:0] idx;

    for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_rom
        localparam logic [12:0] ENT =
            13'(mlp221_pkg::sig_entry(longint'(k), longint'(SIGMOID_TABLE_DEPTH)));
        assign rom[k] = ENT;
    end

    // code + 32768 as unsigned, scaled by depth, top bits pick the bin
    assign offs    = {~net_in[15], net_in[14:0]};
    assign prod    = PW'(offs) * PW'(SIGMOID_TABLE_DEPTH);
    assign idx     = prod[16 +: IW];
    assign sig_out = rom[idx];

endmodule

>>> design/mlp_2_2_1_backprop_step_top.sv
// top level: one online backpropagation step of a 2-2-1 sigmoid network on a shared multiplier
//
//  channel   dir  handshake            contents
//  s_        in   s_tvalid/s_tready    input_a, input_b, target
//  m_        out  m_tvalid/m_tready    net_output, output_error, nine updated weights
//  cfg_      in   cfg_we               learning_rate
//
// each request is accepted, then runs 27 sequencer steps through the
// single 18x18 multiplier and accumulator, which serves every product of the step.
// s_tready is low while a step is running; the result sits in an output register,
// so a new request is taken while the previous result waits. if the previous result
// is still not taken at the last step, the sequencer holds there and commits later.
// reset (synchronous, aresetn low) restores the nine weights and learning rate.
module mlp_2_2_1_backprop_step_top #(
    parameter int SIGMOID_TABLE_DEPTH = 256
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // input_a[15:0], input_b[31:16], target[44:32], zero pad
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [175:0] m_tdata,   // net_output[12:0], output_error[26:13], w_hidden1,
                                    // w_hidden2, w_bias, v_a1, v_b1, v_bias1, v_a2, v_b2,
                                    // v_bias2 (16 bits each from bit 27 up), zero pad
    input  logic         cfg_we,
    input  logic [12:0]  cfg_wdata
);

    // sequencer steps
    localparam logic [4:0] S_A1   = 5'd0;
    localparam logic [4:0] S_B1   = 5'd1;
    localparam logic [4:0] S_A2   = 5'd2;
    localparam logic [4:0] S_B2   = 5'd3;
    localparam logic [4:0] S_DZ1M = 5'd4;
    localparam logic [4:0] S_W1   = 5'd5;
    localparam logic [4:0] S_W2   = 5'd6;
    localparam logic [4:0] S_DZ2M = 5'd7;
    localparam logic [4:0] S_LUTY = 5'd8;
    localparam logic [4:0] S_DYM  = 5'd9;
    localparam logic [4:0] S_DY   = 5'd10;
    localparam logic [4:0] S_DELM = 5'd11;
    localparam logic [4:0] S_DEL  = 5'd12;
    localparam logic [4:0] S_ADM  = 5'd13;
    localparam logic [4:0] S_G1M  = 5'd14;
    localparam logic [4:0] S_AZ1  = 5'd15;
    localparam logic [4:0] S_DJ1M = 5'd16;
    localparam logic [4:0] S_G2M  = 5'd17;
    localparam logic [4:0] S_AZ2  = 5'd18;
    localparam logic [4:0] S_DJ2M = 5'd19;
    localparam logic [4:0] S_A1M  = 5'd20;
    localparam logic [4:0] S_A2M  = 5'd21;
    localparam logic [4:0] S_UA1  = 5'd22;
    localparam logic [4:0] S_UB1  = 5'd23;
    localparam logic [4:0] S_UA2  = 5'd24;
    localparam logic [4:0] S_UB2  = 5'd25;
    localparam logic [4:0] S_DONE = 5'd26;

    localparam logic [12:0] Q12_ONE_C = mlp221_pkg::Q12_ONE;

    // control
    logic       busy_reg;
    logic [4:0] step_reg;
    logic       m_tvalid_reg;
    logic       commit;
    logic       accept;

    // configuration and latched request
    logic [12:0]               alpha_reg;
    logic [12:0]               alpha_c;
    logic signed [15:0]        a_reg, b_reg;
    logic [12:0]               t_reg;

    // weights and their updated copies
    mlp221_pkg::weight_t w1_reg, w2_reg, wb_reg, va1_reg, vb1_reg, vbias1_reg;
    mlp221_pkg::weight_t va2_reg, vb2_reg, vbias2_reg;
    mlp221_pkg::weight_t nw1_reg, nw2_reg, nwb_reg, nva1_reg, nvb1_reg, nvbias1_reg;
    mlp221_pkg::weight_t nva2_reg, nvbias2_reg;
    mlp221_pkg::weight_t nvb2;

    // intermediates
    logic signed [15:0] zin1_reg, zin2_reg, yin_reg;
    logic [12:0]        z1_reg, z2_reg, y_reg;
    logic signed [13:0] err_reg;
    logic [10:0]        dz1_reg, dz2_reg, dy_reg;
    logic signed [17:0] del_reg, ad_reg, tmp_reg, dj1_reg, dj2_reg, a1_reg, a2_reg;

    // shared multiplier and accumulator
    logic signed [17:0] mul_a, mul_b;
    logic               mul_on, mul_add;
    logic signed [35:0] prod;
    logic signed [35:0] acc_reg;
    logic signed [23:0] q;

    // sigmoid lookup
    logic signed [15:0] lut_in;
    logic [12:0]        lut_out;

    mlp221_sig_lut #(
        .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
    ) u_lut (
        .net_in  (lut_in),
        .sig_out (lut_out)
    );

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !busy_reg;
    assign m_tvalid = m_tvalid_reg;
    assign commit   = busy_reg && (step_reg == S_DONE) && (!m_tvalid_reg || m_tready);
    assign alpha_c  = (alpha_reg > Q12_ONE_C) ? Q12_ONE_C : alpha_reg;
    assign q        = acc_reg[35:12];   // floor division by 4096
    assign prod     = mul_a * mul_b;
    assign nvb2     = mlp221_pkg::sat16(25'(q) + 25'(vb2_reg));

    // lookup source per step
    always_comb begin
        unique case (step_reg)
            S_W1:    lut_in = zin2_reg;
            S_LUTY:  lut_in = yin_reg;
            default: lut_in = zin1_reg;
        endcase
    end

    // multiplier operand select per step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_on  = 1'b1;
        mul_add = 1'b0;
        unique case (step_reg)
            S_A1:   begin mul_a = 18'(a_reg); mul_b = 18'(va1_reg); end
            S_B1:   begin mul_a = 18'(b_reg); mul_b = 18'(vb1_reg); mul_add = 1'b1; end
            S_A2:   begin mul_a = 18'(a_reg); mul_b = 18'(va2_reg); end
            S_B2:   begin mul_a = 18'(b_reg); mul_b = 18'(vb2_reg); mul_add = 1'b1; end
            S_DZ1M: begin
                mul_a = signed'(18'(z1_reg));
                mul_b = signed'(18'(Q12_ONE_C)) - signed'(18'(z1_reg));
            end
            S_W1:   begin mul_a = signed'(18'(z1_reg)); mul_b = 18'(w1_reg); end
            S_W2:   begin
                mul_a = signed'(18'(z2_reg)); mul_b = 18'(w2_reg); mul_add = 1'b1;
            end
            S_DZ2M: begin
                mul_a = signed'(18'(z2_reg));
                mul_b = signed'(18'(Q12_ONE_C)) - signed'(18'(z2_reg));
            end
            S_DYM:  begin
                mul_a = signed'(18'(y_reg));
                mul_b = signed'(18'(Q12_ONE_C)) - signed'(18'(y_reg));
            end
            S_DELM: begin mul_a = 18'(err_reg); mul_b = signed'(18'(dy_reg)); end
            S_ADM:  begin mul_a = signed'(18'(alpha_c)); mul_b = del_reg; end
            S_G1M:  begin mul_a = del_reg; mul_b = 18'(w1_reg); end
            S_AZ1:  begin mul_a = ad_reg; mul_b = signed'(18'(z1_reg)); end
            S_DJ1M: begin mul_a = tmp_reg; mul_b = signed'(18'(dz1_reg)); end
            S_G2M:  begin mul_a = del_reg; mul_b = 18'(w2_reg); end
            S_AZ2:  begin mul_a = ad_reg; mul_b = signed'(18'(z2_reg)); end
            S_DJ2M: begin mul_a = tmp_reg; mul_b = signed'(18'(dz2_reg)); end
            S_A1M:  begin mul_a = signed'(18'(alpha_c)); mul_b = dj1_reg; end
            S_A2M:  begin mul_a = signed'(18'(alpha_c)); mul_b = dj2_reg; end
            S_UA1:  begin mul_a = a1_reg; mul_b = 18'(a_reg); end
            S_UB1:  begin mul_a = a1_reg; mul_b = 18'(b_reg); end
            S_UA2:  begin mul_a = a2_reg; mul_b = 18'(a_reg); end
            S_UB2:  begin mul_a = a2_reg; mul_b = 18'(b_reg); end
            default: mul_on = 1'b0;
        endcase
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            a_reg <= s_tdata[15:0];
            b_reg <= s_tdata[31:16];
            t_reg <= (s_tdata[44:32] > Q12_ONE_C) ? Q12_ONE_C : s_tdata[44:32];
        end
        if (busy_reg && mul_on) begin
            acc_reg <= (mul_add ? acc_reg : 36'sd0) + prod;
        end
        if (busy_reg) begin
            unique case (step_reg)
                S_A2:   zin1_reg <= mlp221_pkg::sat16(25'(q) + 25'(vbias1_reg));
                S_B2:   z1_reg   <= lut_out;
                S_DZ1M: zin2_reg <= mlp221_pkg::sat16(25'(q) + 25'(vbias2_reg));
                S_W1:   begin z2_reg <= lut_out; dz1_reg <= q[10:0]; end
                S_DZ2M: yin_reg  <= mlp221_pkg::sat16(25'(q) + 25'(wb_reg));
                S_LUTY: begin y_reg <= lut_out; dz2_reg <= q[10:0]; end
                S_DYM:  err_reg  <= signed'({1'b0, t_reg}) - signed'({1'b0, y_reg});
                S_DY:   dy_reg   <= q[10:0];
                S_DEL:  del_reg  <= q[17:0];
                S_G1M:  ad_reg   <= q[17:0];
                S_AZ1:  tmp_reg  <= q[17:0];
                S_DJ1M: nw1_reg  <= mlp221_pkg::sat16(25'(q) + 25'(w1_reg));
                S_G2M:  dj1_reg  <= q[17:0];
                S_AZ2:  tmp_reg  <= q[17:0];
                S_DJ2M: nw2_reg  <= mlp221_pkg::sat16(25'(q) + 25'(w2_reg));
                S_A1M:  dj2_reg  <= q[17:0];
                S_A2M:  begin
                    a1_reg  <= q[17:0];
                    nwb_reg <= mlp221_pkg::sat16(25'(ad_reg) + 25'(wb_reg));
                end
                S_UA1:  a2_reg   <= q[17:0];
                S_UB1:  begin
                    nva1_reg    <= mlp221_pkg::sat16(25'(q) + 25'(va1_reg));
                    nvbias1_reg <= mlp221_pkg::sat16(25'(a1_reg) + 25'(vbias1_reg));
                end
                S_UA2:  begin
                    nvb1_reg    <= mlp221_pkg::sat16(25'(q) + 25'(vb1_reg));
                    nvbias2_reg <= mlp221_pkg::sat16(25'(a2_reg) + 25'(vbias2_reg));
                end
                S_UB2:  nva2_reg <= mlp221_pkg::sat16(25'(q) + 25'(va2_reg));
                default: ;
            endcase
        end
        // result register, packed lowest field first
        if (commit) begin
            m_tdata <= {5'd0, nvbias2_reg, nvb2, nva2_reg, nvbias1_reg, nvb1_reg,
                        nva1_reg, nwb_reg, nw2_reg, nw1_reg, err_reg, y_reg};
        end
    end

    // control, configuration and weight state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            step_reg     <= S_A1;
            m_tvalid_reg <= 1'b0;
            alpha_reg    <= mlp221_pkg::RST_ALPHA;
            w1_reg       <= mlp221_pkg::RST_W1;
            w2_reg       <= mlp221_pkg::RST_W2;
            wb_reg       <= mlp221_pkg::RST_WB;
            va1_reg      <= mlp221_pkg::RST_VA1;
            vb1_reg      <= mlp221_pkg::RST_VB1;
            vbias1_reg   <= mlp221_pkg::RST_VBIAS1;
            va2_reg      <= mlp221_pkg::RST_VA2;
            vb2_reg      <= mlp221_pkg::RST_VB2;
            vbias2_reg   <= mlp221_pkg::RST_VBIAS2;
        end else begin
            if (cfg_we) begin
                alpha_reg <= cfg_wdata;
            end
            if (accept) begin
                busy_reg <= 1'b1;
                step_reg <= S_A1;
            end else if (busy_reg && step_reg != S_DONE) begin
                step_reg <= step_reg + 5'd1;
            end
            if (commit) begin
                busy_reg     <= 1'b0;
                m_tvalid_reg <= 1'b1;
                w1_reg       <= nw1_reg;
                w2_reg       <= nw2_reg;
                wb_reg       <= nwb_reg;
                va1_reg      <= nva1_reg;
                vb1_reg      <= nvb1_reg;
                vbias1_reg   <= nvbias1_reg;
                va2_reg      <= nva2_reg;
                vb2_reg      <= nvb2;
                vbias2_reg   <= nvbias2_reg;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

>>> tb/testbench.sv
// self-checking testbench for the 2-2-1 backpropagation training step block
`timescale 1ns / 1ps

module testbench;

    localparam int TABLE_DEPTH = 256;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1200;

    typedef struct packed {
        logic [12:0] net_output;
        logic [13:0] output_error;
        logic [15:0] w1, w2, wb, va1, vb1, vbias1, va2, vb2, vbias2;
    } step_result_t;

    typedef struct {
        logic [15:0] in_a;
        logic [15:0] in_b;
        logic [12:0] tgt;
        bit          has_fixed;
        logic [12:0] fixed_y;
        logic [13:0] fixed_err;
    } stim_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;
    logic         cfg_we = 1'b0;
    logic [12:0]  cfg_wdata = '0;

    mlp_2_2_1_backprop_step_top #(.SIGMOID_TABLE_DEPTH(TABLE_DEPTH)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state: own copy of the weights, rate and sigmoid table
    longint sig_lut [TABLE_DEPTH];
    longint alpha_q;
    longint w1_q, w2_q, wb_q, va1_q, vb1_q, vbias1_q, va2_q, vb2_q, vbias2_q;

    step_result_t pending_steps[$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    bit long_hold = 1'b0;

    // sigmoid of a non-negative q12 code, via exp(-u/4096) in q30 from a taylor series and powers of exp(-1)
    function automatic longint pos_sigmoid(longint u);
        longint unsigned f, term;
        longint acc, e;
        f = (u & 4095) << 18;
        term = 64'd1073741824;
        acc = 64'sd1073741824;
        for (int n = 1; n <= 14; n++) begin
            term = ((term * f) >> 30) / n;
            if (n % 2 == 1) acc = acc - longint'(term);
            else acc = acc + longint'(term);
        end
        e = (acc < 0) ? 0 : acc;
        for (longint k = 0; k < (u >>> 12); k++) e = (e * 64'sd395007543) >>> 30;
        return (64'sd4096 * 64'sd1073741824 + (64'sd1073741824 + e) / 2)
               / (64'sd1073741824 + e);
    endfunction

    function automatic longint floor_q12(longint x);
        return x >>> 12;
    endfunction

    function automatic longint clamp16(longint x);
        return (x > 32767) ? 32767 : ((x < -32768) ? -32768 : x);
    endfunction

    function automatic longint sigmoid_of(longint x);
        longint idx;
        idx = ((clamp16(x) + 32768) * TABLE_DEPTH) >>> 16;
        if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
        return sig_lut[idx];
    endfunction

    function automatic longint slope_of(longint x);
        longint s;
        s = sigmoid_of(x);
        return floor_q12(s * (4096 - s));
    endfunction

    task automatic reset_weights();
        longint c;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            c = ((2 * k + 1) * 32768) / TABLE_DEPTH - 32768;
            sig_lut[k] = (c >= 0) ? pos_sigmoid(c) : 4096 - pos_sigmoid(-c);
        end
        alpha_q = 1024;
        w1_q = 1638; w2_q = 410; wb_q = -819;
        va1_q = 2458; vb1_q = -410; vbias1_q = 1229;
        va2_q = -1229; vb2_q = 1638; vbias2_q = 2048;
    endtask

    // one training step; updates the predictor weights and returns the result
    function automatic step_result_t train_step(logic [15:0] ia, logic [15:0] ib,
                                                logic [12:0] tg);
        step_result_t r;
        longint a, b, t, al, zin1, zin2, z1, z2, yin, y, err, del, ad, dj1, dj2, a1, a2;
        longint w1o, w2o;
        a = longint'($signed(ia));
        b = longint'($signed(ib));
        t = (tg > 4096) ? 4096 : tg;
        al = (alpha_q > 4096) ? 4096 : alpha_q;
        w1o = w1_q; w2o = w2_q;
        zin1 = clamp16(floor_q12(a * va1_q + b * vb1_q) + vbias1_q);
        zin2 = clamp16(floor_q12(a * va2_q + b * vb2_q) + vbias2_q);
        z1 = sigmoid_of(zin1);
        z2 = sigmoid_of(zin2);
        yin = clamp16(floor_q12(z1 * w1o + z2 * w2o) + wb_q);
        y = sigmoid_of(yin);
        err = t - y;
        del = floor_q12(err * slope_of(yin));
        ad = floor_q12(al * del);
        dj1 = floor_q12(floor_q12(del * w1o) * slope_of(zin1));
        dj2 = floor_q12(floor_q12(del * w2o) * slope_of(zin2));
        a1 = floor_q12(al * dj1);
        a2 = floor_q12(al * dj2);
        w1_q = clamp16(w1_q + floor_q12(ad * z1));
        w2_q = clamp16(w2_q + floor_q12(ad * z2));
        wb_q = clamp16(wb_q + ad);
        va1_q = clamp16(va1_q + floor_q12(a1 * a));
        vb1_q = clamp16(vb1_q + floor_q12(a1 * b));
        vbias1_q = clamp16(vbias1_q + a1);
        va2_q = clamp16(va2_q + floor_q12(a2 * a));
        vb2_q = clamp16(vb2_q + floor_q12(a2 * b));
        vbias2_q = clamp16(vbias2_q + a2);
        r.net_output = y[12:0];
        r.output_error = err[13:0];
        r.w1 = w1_q[15:0]; r.w2 = w2_q[15:0]; r.wb = wb_q[15:0];
        r.va1 = va1_q[15:0]; r.vb1 = vb1_q[15:0]; r.vbias1 = vbias1_q[15:0];
        r.va2 = va2_q[15:0]; r.vb2 = vb2_q[15:0]; r.vbias2 = vbias2_q[15:0];
        return r;
    endfunction

    function automatic step_result_t unpack_result(logic [175:0] d);
        step_result_t r;
        r.net_output = d[12:0];
        r.output_error = d[26:13];
        r.w1 = d[42:27];   r.w2 = d[58:43];    r.wb = d[74:59];
        r.va1 = d[90:75];  r.vb1 = d[106:91];  r.vbias1 = d[122:107];
        r.va2 = d[138:123]; r.vb2 = d[154:139]; r.vbias2 = d[170:155];
        return r;
    endfunction

    // directed rows, all checked against the predictor
    stim_row_t directed_rows[$];

    task automatic add_row(logic [15:0] ia, logic [15:0] ib, logic [12:0] tg);
        stim_row_t r;
        r.in_a = ia; r.in_b = ib; r.tgt = tg;
        r.has_fixed = 1'b0; r.fixed_y = '0; r.fixed_err = '0;
        directed_rows.push_back(r);
    endtask

    // send one request: waits for acceptance, records the expected result
    task automatic send_request(logic [15:0] ia, logic [15:0] ib, logic [12:0] tg,
                                bit has_fixed, logic [12:0] fy, logic [13:0] fe);
        step_result_t r;
        s_tdata <= {3'b000, tg, ib, ia};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!(s_tready === 1'b1));
        r = train_step(ia, ib, tg);
        if (has_fixed && (r.net_output != fy || r.output_error != fe)) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("directed row: predicted y %0d err %0d, table y %0d err %0d",
                         r.net_output, $signed(r.output_error), fy, $signed(fe));
        end
        pending_steps.push_back(r);
        @(negedge aclk);
    endtask

    task automatic drain_results();
        while (pending_steps.size() != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_rate(logic [12:0] v);
        cfg_wdata <= v;
        cfg_we <= 1'b1;
        @(posedge aclk);
        alpha_q = v;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // random request with a burst/gap pattern on the sender side
    task automatic random_phase(int count);
        int burst;
        logic [15:0] ia, ib;
        logic [12:0] tg;
        burst = 0;
        for (int i = 0; i < count; i++) begin
            if (burst == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(0, 6)) @(negedge aclk);
                burst = $urandom_range(1, 12);
            end
            case ($urandom_range(0, 9))
                0: ia = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                1, 2: ia = $urandom;
                default: ia = 16'($signed($urandom_range(0, 8192)) - 4096);
            endcase
            case ($urandom_range(0, 9))
                0: ib = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                1, 2: ib = $urandom;
                default: ib = 16'($signed($urandom_range(0, 8192)) - 4096);
            endcase
            tg = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 4096));
            send_request(ia, ib, tg, 1'b0, '0, '0);
            burst--;
        end
        s_tvalid <= 1'b0;
    endtask

    // receiver: stall pattern of its own, plus one long hold-off
    initial begin
        int hold;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                for (hold = 0; hold < 300; hold++) @(negedge aclk);
                long_hold = 1'b0;
            end
            case ($urandom_range(0, 7))
                0, 1: m_tready <= 1'b0;
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // result checking at the rising edge
    always @(posedge aclk) begin
        step_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = unpack_result(m_tdata);
            if (pending_steps.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result %h", m_tdata);
            end else begin
                want = pending_steps.pop_front();
                if (got !== want || m_tdata[175:171] !== 5'b0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result mismatch: expected %h got %h", want, got);
                end
            end
        end
    end

    // watchdog: cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        stim_row_t row;
        logic [12:0] rate_set [6];
        reset_weights();
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // first step from reset: zero inputs, target zero
        add_row(16'h0000, 16'h0000, 13'd0);
        add_row(16'h7fff, 16'h7fff, 13'd4096);
        add_row(16'h8000, 16'h8000, 13'd0);
        add_row(16'h7fff, 16'h8000, 13'd4096);
        add_row(16'h8000, 16'h7fff, 13'd2048);
        add_row(16'h1000, 16'hf000, 13'd8191);   // target above one, clamped
        add_row(16'hffff, 16'h0001, 13'd4097);
        add_row(16'h5555, 16'haaaa, 13'd1);
        add_row(16'haaaa, 16'h5555, 13'd4095);
        add_row(16'h0000, 16'h0000, 13'd4096);
        for (int i = 0; i < directed_rows.size(); i++) begin
            row = directed_rows[i];
            send_request(row.in_a, row.in_b, row.tgt, row.has_fixed,
                         row.fixed_y, row.fixed_err);
        end
        s_tvalid <= 1'b0;
        drain_results();

        // learning rate extremes, including values past one that clamp
        rate_set[0] = 13'd0;
        rate_set[1] = 13'd4096;
        rate_set[2] = 13'd8191;
        rate_set[3] = 13'd1;
        rate_set[4] = 13'd4097;
        rate_set[5] = 13'd1024;
        for (int p = 0; p < 6; p++) begin
            write_rate(rate_set[p]);
            add_row(16'h7fff, 16'h8000, 13'd4096);
            row = directed_rows[directed_rows.size() - 1];
            send_request(row.in_a, row.in_b, row.tgt, 1'b0, '0, '0);
            s_tvalid <= 1'b0;
            if (p == 1) long_hold = 1'b1;
            random_phase(RANDOM_ITEMS / 8);
            drain_results();
        end
        write_rate(13'($urandom_range(0, 8191)));
        random_phase(RANDOM_ITEMS / 4);
        drain_results();

        if (mismatch_count == 0 && pending_steps.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> files.f
design/mlp221_pkg.sv
design/mlp221_sig_lut.sv
design/mlp_2_2_1_backprop_step_top.sv
tb/testbench.sv
